// ----- design/assert_macros.svh -----
// Assertion macros for the checker file, rve_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, reset included.
`define RVE_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check on every rising clock edge outside reset.
`define RVE_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`endif

// ----- design/rve_pkg.sv -----
// Shared widths, register indexes and reset values for the range velocity estimator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rve_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int THRESH_W   = 24;
  localparam int RATE_W     = 10;
  localparam int OFS_W      = 25;
  localparam int ADJ_W      = 26;
  localparam int DIFF_W     = 27;
  localparam int PROD_W     = DIFF_W + RATE_W + 1;
  localparam int VEL_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int WINDOW_DEFAULT = 78;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 2'd2;

  localparam logic [SAMPLE_W-1:0] MAX_DISTANCE_RST   = 24'd5242880;
  localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST = 24'd9830;
  localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST    = 10'd75;

  localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- design/rve_if.sv -----
// Channel interfaces: range samples in, velocities out, register writes.
// Depends on rve_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rve_sample_if;
  logic                         valid;
  logic                         ready;
  logic [rve_pkg::SAMPLE_W-1:0] range_sample;
  modport source (output valid, output range_sample, input ready);
  modport sink   (input valid, input range_sample, output ready);
endinterface

interface rve_velocity_if;
  logic                             valid;
  logic                             ready;
  logic signed [rve_pkg::VEL_W-1:0] velocity;
  modport source (output valid, output velocity, input ready);
  modport sink   (input valid, input velocity, output ready);
endinterface

interface rve_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rve_pkg::CFG_IDX_W-1:0]  index;
  logic [rve_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/rve_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on rve_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module rve_ram #(
  parameter int WIDTH = rve_pkg::VEL_W,
  parameter int DEPTH = rve_pkg::WINDOW_DEFAULT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/rve_div.sv -----
// Pipelined division of the signed window sum by WINDOW through a constant reciprocal,
// truncated toward zero; four stages. Depends on rve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rve_div #(
  parameter int WINDOW = rve_pkg::WINDOW_DEFAULT,
  localparam int SUM_W = rve_pkg::VEL_W + $clog2(WINDOW),
  localparam int Q_W = rve_pkg::VEL_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [SUM_W-1:0] in_sum,
  output logic                         out_valid,
  output logic signed [Q_W-1:0]        out_quotient
);

  // quotient = (|sum| * ceil(2^SHIFT / WINDOW)) >> SHIFT, exact for |sum| < 2^SUM_W
  localparam int LOG_W = $clog2(WINDOW);
  localparam int SHIFT = SUM_W + LOG_W;
  localparam int REC_W = SUM_W + 1;
  localparam int ML    = SUM_W / 2;
  localparam int MH    = SUM_W - ML;
  localparam int RL    = REC_W / 2;
  localparam int RH    = REC_W - RL;
  localparam int PW    = SUM_W + REC_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [REC_W-1:0] RECIP = RECIP64[REC_W-1:0];

  logic                    v1;
  logic                    v2;
  logic                    v3;
  logic                    v4;
  logic signed [SUM_W-1:0] sum1;
  logic [SUM_W-1:0]        mag2;
  logic                    neg2;
  logic                    neg3;
  logic                    neg4;
  logic [ML+RL-1:0]        pp_ll;
  logic [ML+RH-1:0]        pp_lh;
  logic [MH+RL-1:0]        pp_hl;
  logic [MH+RH-1:0]        pp_hh;
  logic [PW-1:0]           prod;
  logic [Q_W-1:0]          quo4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      sum1  <= in_sum;
      mag2  <= sum1[SUM_W-1] ? SUM_W'(-sum1) : SUM_W'(sum1);
      neg2  <= sum1[SUM_W-1];
      pp_ll <= (ML+RL)'(mag2[ML-1:0]) * (ML+RL)'(RECIP[RL-1:0]);
      pp_lh <= (ML+RH)'(mag2[ML-1:0]) * (ML+RH)'(RECIP[REC_W-1:RL]);
      pp_hl <= (MH+RL)'(mag2[SUM_W-1:ML]) * (MH+RL)'(RECIP[RL-1:0]);
      pp_hh <= (MH+RH)'(mag2[SUM_W-1:ML]) * (MH+RH)'(RECIP[REC_W-1:RL]);
      neg3  <= neg2;
      quo4  <= prod[SHIFT+Q_W-1:SHIFT];
      neg4  <= neg3;
    end
  end

  assign prod = (PW'(pp_hh) << (ML + RL)) + (PW'(pp_hl) << ML) +
                (PW'(pp_lh) << RL) + PW'(pp_ll);

  assign out_valid    = v4;
  assign out_quotient = neg4 ? $signed(-quo4) : $signed(quo4);

endmodule

`default_nettype wire

// ----- design/range_velocity_estimator_unit.sv -----
// Range velocity estimator: windowed mean of pairwise velocities from range samples.
// Sustains one sample per cycle, with one history RAM read and one write per cycle and a
// four-stage reciprocal divider, unless the full two-entry output buffer stalls it.
// Synchronous reset clears state and loads register defaults; history reads as zero
// until the write pointer first wraps, so no clearing pass is needed.
// Depends on rve_pkg, rve_if, rve_ram, rve_div.
`timescale 1ns / 1ps
`default_nettype none

module range_velocity_estimator_unit #(
  parameter int WINDOW = rve_pkg::WINDOW_DEFAULT
) (
  input wire logic      clk,
  input wire logic      rst,
  rve_sample_if.sink    samples,
  rve_velocity_if.source results,
  rve_cfg_if.sink       cfg
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = rve_pkg::VEL_W + $clog2(WINDOW);
  localparam int VW    = rve_pkg::VEL_W;

  // configuration
  logic [rve_pkg::SAMPLE_W-1:0] max_distance;
  logic [rve_pkg::THRESH_W-1:0] jump_threshold;
  logic [rve_pkg::RATE_W-1:0]   sample_rate;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance   <= rve_pkg::MAX_DISTANCE_RST;
      jump_threshold <= rve_pkg::JUMP_THRESHOLD_RST;
      sample_rate    <= rve_pkg::SAMPLE_RATE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        rve_pkg::REG_MAX_DISTANCE:   max_distance   <= cfg.data[rve_pkg::SAMPLE_W-1:0];
        rve_pkg::REG_JUMP_THRESHOLD: jump_threshold <= cfg.data[rve_pkg::THRESH_W-1:0];
        rve_pkg::REG_SAMPLE_RATE:    sample_rate    <= cfg.data[rve_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and output buffer
  logic                 adv;
  logic [1:0]           cnt;
  logic signed [VW-1:0] buf0;
  logic signed [VW-1:0] buf1;
  logic                 div_valid;
  logic signed [VW-1:0] div_quotient;
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign adv    = (cnt != 2'd2) || results.ready;
  assign accept = samples.valid && adv;
  assign push   = adv && div_valid;
  assign pop    = results.valid && results.ready;

  assign samples.ready    = adv;
  assign results.valid    = cnt != 2'd0;
  assign results.velocity = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push && pop) begin
      if (cnt == 2'd1) begin
        buf0 <= div_quotient;
      end else begin
        buf0 <= buf1;
        buf1 <= div_quotient;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= div_quotient;
      end else begin
        buf1 <= div_quotient;
      end
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

  // stage 0: raw hold, jump offset, adjusted distance
  logic [rve_pkg::SAMPLE_W-1:0]      last_raw;
  logic signed [rve_pkg::ADJ_W-1:0]  last_adj;
  logic signed [rve_pkg::OFS_W-1:0]  ofs;
  logic [PTR_W-1:0]                  wptr;
  logic                              wrapped;

  logic [rve_pkg::SAMPLE_W-1:0]      raw;
  logic signed [rve_pkg::OFS_W-1:0]  step;
  logic [rve_pkg::OFS_W-1:0]         mag;
  logic                              jump;
  logic signed [rve_pkg::ADJ_W-1:0]  ofs_sub;
  logic signed [rve_pkg::OFS_W-1:0]  ofs_next;
  logic signed [rve_pkg::ADJ_W-1:0]  adjusted;
  logic signed [rve_pkg::DIFF_W-1:0] diff;
  logic                              wptr_last;

  always_comb begin
    raw  = (samples.range_sample < max_distance) ? samples.range_sample : last_raw;
    step = $signed({1'b0, raw}) - $signed({1'b0, last_raw});
    mag  = step[rve_pkg::OFS_W-1] ? rve_pkg::OFS_W'(-step) : rve_pkg::OFS_W'(step);
    jump = (mag > {1'b0, jump_threshold}) && (last_adj != '0);
    ofs_sub = rve_pkg::ADJ_W'(ofs) - rve_pkg::ADJ_W'(step);
    if (ofs_sub[rve_pkg::ADJ_W-1] != ofs_sub[rve_pkg::ADJ_W-2]) begin
      ofs_next = ofs_sub[rve_pkg::ADJ_W-1] ? rve_pkg::OFS_MIN : rve_pkg::OFS_MAX;
    end else begin
      ofs_next = ofs_sub[rve_pkg::OFS_W-1:0];
    end
    if (!jump) begin
      ofs_next = ofs;
    end
    adjusted = $signed({2'b00, raw}) + rve_pkg::ADJ_W'(ofs_next);
    // first nonzero step from a zero distance gives zero velocity
    if (last_adj == '0) begin
      diff = '0;
    end else begin
      diff = rve_pkg::DIFF_W'(adjusted) - rve_pkg::DIFF_W'(last_adj);
    end
  end

  assign wptr_last = wptr == PTR_W'(WINDOW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= '0;
      last_adj <= '0;
      ofs      <= '0;
      wptr     <= '0;
      wrapped  <= 1'b0;
    end else if (accept) begin
      last_raw <= raw;
      last_adj <= adjusted;
      ofs      <= ofs_next;
      wptr     <= wptr_last ? '0 : wptr + 1'b1;
      if (wptr_last) begin
        wrapped <= 1'b1;
      end
    end
  end

  // stage 1: scale by sample rate and saturate; history entry arrives from RAM
  logic                              s1_valid;
  logic signed [rve_pkg::DIFF_W-1:0] s1_diff;
  logic [PTR_W-1:0]                  s1_addr;
  logic                              s1_old_ok;
  logic signed [rve_pkg::PROD_W-1:0] prod;
  logic signed [VW-1:0]              vel;
  logic [VW-1:0]                     ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
    if (adv) begin
      s1_diff   <= diff;
      s1_addr   <= wptr;
      s1_old_ok <= wrapped;
    end
  end

  always_comb begin
    prod = $signed(s1_diff) * $signed({1'b0, sample_rate});
    if ((&prod[rve_pkg::PROD_W-1:VW-1]) || !(|prod[rve_pkg::PROD_W-1:VW-1])) begin
      vel = prod[VW-1:0];
    end else begin
      vel = prod[rve_pkg::PROD_W-1] ? rve_pkg::VEL_MIN : rve_pkg::VEL_MAX;
    end
  end

  // stage 2: running sum update and history write-back
  logic                    s2_valid;
  logic signed [VW-1:0]    s2_vel;
  logic signed [VW-1:0]    s2_old;
  logic [PTR_W-1:0]        s2_addr;
  logic signed [SUM_W-1:0] vel_sum;
  logic signed [SUM_W-1:0] sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_vel  <= vel;
      s2_old  <= s1_old_ok ? $signed(ram_rdata) : '0;
      s2_addr <= s1_addr;
    end
  end

  assign sum_next = vel_sum - SUM_W'(s2_old) + SUM_W'(s2_vel);

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_sum <= '0;
    end else if (adv && s2_valid) begin
      vel_sum <= sum_next;
    end
  end

  rve_ram #(
    .WIDTH (VW),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (adv && s2_valid),
    .waddr (s2_addr),
    .wdata (s2_vel),
    .re    (adv),
    .raddr (wptr),
    .rdata (ram_rdata)
  );

  rve_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (s2_valid),
    .in_sum       (sum_next),
    .out_valid    (div_valid),
    .out_quotient (div_quotient)
  );

endmodule

`default_nettype wire

// ----- design/rve_checker.sv -----
// Port-level checks on the range velocity estimator, bound to the top level.
// Depends on assert_macros.svh, rve_pkg and range_velocity_estimator_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rve_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [rve_pkg::VEL_W-1:0] out_velocity
);

  `RVE_ASSERT(a_reset_empties, clk, rst |=> !out_valid)
  `RVE_ASSERT(a_ready_on_take, clk, out_ready |-> in_ready)
  `RVE_ASSERT_RST(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)
  `RVE_ASSERT_RST(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_velocity))

endmodule

bind range_velocity_estimator_unit rve_checker u_rve_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_velocity (results.velocity)
);

`default_nettype wire

// ----- bench/rve_velocity_check.sv -----
// Velocity checker: watches the sample, velocity and register channels, predicts each
// windowed mean velocity and compares it with the block's output.
// Depends on rve_pkg and rve_if.
`timescale 1ns / 1ps

module rve_velocity_check (
  input  logic    clk,
  input  logic    rst,
  rve_sample_if   samples,
  rve_velocity_if results,
  rve_cfg_if      cfg,
  output int      mismatches,
  output int      pending
);

  localparam int WINDOW = rve_pkg::WINDOW_DEFAULT;
  localparam int SW     = rve_pkg::SAMPLE_W;
  localparam int VW     = rve_pkg::VEL_W;
  localparam int OW     = rve_pkg::OFS_W;
  localparam int AW     = rve_pkg::ADJ_W;
  localparam int SUM_W  = rve_pkg::VEL_W + $clog2(WINDOW);

  logic [SW-1:0]                max_distance;
  logic [rve_pkg::THRESH_W-1:0] jump_threshold;
  logic [rve_pkg::RATE_W-1:0]   sample_rate;
  logic [SW-1:0]                prev_raw;
  logic signed [AW-1:0]         prev_adjusted;
  logic signed [OW-1:0]         jump_offset;
  logic signed [VW-1:0]         history [WINDOW];
  int unsigned                  hist_ptr;
  logic signed [SUM_W-1:0]      vel_sum;
  logic signed [VW-1:0]         expected_velocity [$];

  function automatic logic signed [VW-1:0] mean_velocity(logic [SW-1:0] sample);
    logic [SW-1:0] raw;
    longint step, mag, ofs, adjusted, vel;
    raw = (sample < max_distance) ? sample : prev_raw;
    step = longint'(raw) - longint'(prev_raw);
    mag = (step < 0) ? -step : step;
    if (mag > longint'(jump_threshold) && prev_adjusted != 0) begin
      ofs = longint'(jump_offset) - step;
      if (ofs > longint'(rve_pkg::OFS_MAX)) ofs = longint'(rve_pkg::OFS_MAX);
      if (ofs < longint'(rve_pkg::OFS_MIN)) ofs = longint'(rve_pkg::OFS_MIN);
      jump_offset = OW'(ofs);
    end
    adjusted = longint'(raw) + longint'(jump_offset);
    // first step away from zero carries no velocity
    if (prev_adjusted == 0 && adjusted != 0) begin
      vel = 0;
    end else begin
      vel = (adjusted - longint'(prev_adjusted)) * longint'(sample_rate);
      if (vel > longint'(rve_pkg::VEL_MAX)) vel = longint'(rve_pkg::VEL_MAX);
      if (vel < longint'(rve_pkg::VEL_MIN)) vel = longint'(rve_pkg::VEL_MIN);
    end
    vel_sum = SUM_W'(longint'(vel_sum) - longint'(history[hist_ptr]) + vel);
    history[hist_ptr] = VW'(vel);
    hist_ptr = (hist_ptr == WINDOW - 1) ? 0 : hist_ptr + 1;
    prev_raw = raw;
    prev_adjusted = AW'(adjusted);
    return VW'(longint'(vel_sum) / longint'(WINDOW));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      max_distance = rve_pkg::MAX_DISTANCE_RST;
      jump_threshold = rve_pkg::JUMP_THRESHOLD_RST;
      sample_rate = rve_pkg::SAMPLE_RATE_RST;
      prev_raw = '0;
      prev_adjusted = '0;
      jump_offset = '0;
      foreach (history[i]) history[i] = '0;
      hist_ptr = 0;
      vel_sum = '0;
      expected_velocity.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rve_pkg::REG_MAX_DISTANCE:   max_distance = cfg.data;
          rve_pkg::REG_JUMP_THRESHOLD: jump_threshold = cfg.data;
          rve_pkg::REG_SAMPLE_RATE:    sample_rate = cfg.data[rve_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        expected_velocity = {expected_velocity, mean_velocity(samples.range_sample)};
      if (results.valid && results.ready) begin
        if (expected_velocity.size() == 0) begin
          $display("%0t velocity transfer with none expected: expected none, got %0d",
                   $time, results.velocity);
          mismatches++;
        end else begin
          logic signed [VW-1:0] want;
          want = expected_velocity.pop_front();
          if (results.velocity !== want) begin
            $display("%0t velocity mismatch: expected %0d, got %0d",
                     $time, want, results.velocity);
            mismatches++;
          end
        end
      end
    end
    pending = expected_velocity.size();
  end

endmodule

// ----- bench/range_velocity_estimator_unit_tb.sv -----
// Testbench top for the range velocity estimator: drives range samples and register
// writes, stalls the velocity side, and gives the verdict from the velocity checker.
// Depends on rve_pkg, rve_if, range_velocity_estimator_unit and rve_velocity_check.
`timescale 1ns / 1ps

module range_velocity_estimator_unit_tb;

  localparam int SW           = rve_pkg::SAMPLE_W;
  localparam int DW           = rve_pkg::CFG_DATA_W;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 265;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [rve_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned SAMPLE_TOP = 24'hFFFFFF;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  bit   sample_xfer;
  bit   velocity_xfer;
  bit   cfg_xfer;
  bit   calm;
  bit   hold_req;

  int unsigned   cur_max = 32'(rve_pkg::MAX_DISTANCE_RST);
  int unsigned   cur_thr = 32'(rve_pkg::JUMP_THRESHOLD_RST);
  logic [SW-1:0] track = '0;

  rve_sample_if   sample_ch ();
  rve_velocity_if velocity_ch ();
  rve_cfg_if      cfg_ch ();

  range_velocity_estimator_unit DUT (
    .clk,
    .rst,
    .samples (sample_ch),
    .results (velocity_ch),
    .cfg     (cfg_ch)
  );

  rve_velocity_check velocity_check (
    .clk,
    .rst,
    .samples    (sample_ch),
    .results    (velocity_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    sample_xfer <= sample_ch.valid && sample_ch.ready;
    velocity_xfer <= velocity_ch.valid && velocity_ch.ready;
    cfg_xfer <= cfg_ch.valid && cfg_ch.ready;
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(negedge clk);
      if (sample_xfer || velocity_xfer || cfg_xfer) idle_run = 0;
      else idle_run++;
    end
    $display("range_velocity_estimator_unit_tb failed");
    $finish;
  end

  // velocity side: random stalls, plus one long hold-off on request
  initial begin
    velocity_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        velocity_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      velocity_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic send_sample(input logic [SW-1:0] value);
    if (!calm && $urandom_range(0, 99) < 16) begin
      sample_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 16);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.range_sample <= value;
    do @(negedge clk); while (!sample_xfer);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rve_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(negedge clk); while (!cfg_xfer);
  endtask

  task automatic configure(input logic [DW-1:0] max_d, thr, rate_word);
    drain();
    write_reg(rve_pkg::REG_MAX_DISTANCE, max_d);
    write_reg(rve_pkg::REG_JUMP_THRESHOLD, thr);
    write_reg(rve_pkg::REG_SAMPLE_RATE, rate_word);
    cfg_ch.valid <= 1'b0;
    cur_max = 32'(max_d);
    cur_thr = 32'(thr);
  endtask

  // mostly a smooth track with steps near the threshold, some jumps and invalid samples
  function automatic logic [SW-1:0] next_range_sample();
    int unsigned pick, span;
    longint pos;
    pick = $urandom_range(0, 99);
    if (pick >= 85 || cur_max == 0) return SW'($urandom);
    if (pick >= 75) return SW'(pick[0] ? cur_max : $urandom_range(SAMPLE_TOP, cur_max));
    if (pick >= 65) begin
      track = SW'($urandom_range(cur_max - 1, 0));
      return track;
    end
    span = (cur_thr > 32'h40000) ? 32'h40000 : ((cur_thr < 16) ? 16 : cur_thr + 1);
    pos = longint'(track);
    if (pick[0]) pos = pos + longint'($urandom_range(span, 0));
    else pos = pos - longint'($urandom_range(span, 0));
    if (pos < 0) pos = 0;
    if (pos > longint'(cur_max) - 1) pos = longint'(cur_max) - 1;
    track = SW'(pos);
    return track;
  endfunction

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.range_sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = rve_pkg::REG_MAX_DISTANCE;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // register defaults: zero start, first step, threshold edges, invalid holds
    send_sample(24'h000000);
    send_sample(24'h100000);
    send_sample(24'h100100);
    send_sample(24'h102766);
    send_sample(24'h104DCD);
    send_sample(24'hFFFFFF);
    send_sample(rve_pkg::MAX_DISTANCE_RST);
    send_sample(rve_pkg::MAX_DISTANCE_RST - 24'd1);
    send_sample(24'h000000);

    // velocity saturation, both signs
    configure(24'hFFFFFF, 24'hFFFFFF, 24'd1023);
    send_sample(24'h000001);
    send_sample(24'hFFFFFE);
    send_sample(24'h000001);

    // offset saturation: climb by jumps, then the other way
    configure(24'hFFFFFF, 24'h7FFFFF, 24'd1);
    send_sample(24'h000001);
    send_sample(24'hFFFFFE);
    send_sample(24'h7FFFFF);
    send_sample(24'h000001);
    send_sample(24'hFFFFFE);
    send_sample(24'h000001);
    send_sample(24'h7FFFFF);
    send_sample(24'hFFFFFE);
    send_sample(24'h000001);
    send_sample(24'h7FFFFF);
    send_sample(24'hFFFFFE);
    send_sample(24'h000001);

    // everything invalid, zero rate, write to the unmapped index
    configure(24'h000000, 24'h000000, 24'd0);
    @(negedge clk);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_ch.valid <= 1'b0;
    send_sample(24'h123456);
    send_sample(24'h000000);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(rve_pkg::MAX_DISTANCE_RST, rve_pkg::JUMP_THRESHOLD_RST,
                     DW'(rve_pkg::SAMPLE_RATE_RST));
        1: configure(24'hFFFFFF, 24'h000000, 24'd1000);
        2: configure(DW'($urandom_range(SAMPLE_TOP, 24'h100000)),
                     DW'($urandom_range(24'h10000, 0)),
                     {14'($urandom_range(14'h3FFF, 0)), 10'($urandom_range(1000, 1))});
        3: configure(DW'($urandom_range(SAMPLE_TOP, 1)), DW'($urandom), 24'd1);
        default: configure(24'hFFFFFF, DW'($urandom_range(24'h4000, 0)), 24'd1023);
      endcase
      calm = (ph == 0);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (ph == 1 && n == 100) hold_req = 1'b1;
        if (ph == 2 && n == 130) begin
          drain();
          @(negedge clk);
        end
        send_sample(next_range_sample());
      end
    end
    calm = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("range_velocity_estimator_unit_tb passed");
    end else begin
      $display("range_velocity_estimator_unit_tb failed");
    end
    $finish;
  end

endmodule
